// File: sv/slga_pkg.sv
// Package for the sorted link group aggregator.
// Holds the controller state type, the command and status structs and fixed widths.
// No dependencies.
package slga_pkg;

    localparam int OUT_ID_BITS = 48;
    localparam int CNT_BITS    = 32;
    localparam int SUM_BITS    = 64;
    localparam int SPAN_BITS   = 32;
    localparam int CFG_BITS    = 32;
    localparam int DIV_STEPS   = 64;
    localparam int STEP_BITS   = 7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_DECIDE,
        S_DIV,
        S_FIX,
        S_DIST,
        S_CHECK,
        S_EMIT_GRP,
        S_AFTER,
        S_MARK
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic accumulate;
        logic load_group;
        logic clear_group;
        logic div_start;
        logic div_step;
        logic fix_avg;
        logic calc_dist;
        logic emit_group;
        logic emit_mark;
    } t_cmd;

    typedef struct packed {
        logic is_end;
        logic match;
        logic open;
        logic div_done;
        logic keep;
        logic out_free;
    } t_sts;

endpackage

// File: sv/slga_if.sv
// Channel interfaces of the sorted link group aggregator: input, result and config.
// Depends on slga_pkg for the fixed field widths.
interface slga_in_if #(
    parameter int ID_BITS     = 48,
    parameter int OFFSET_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [ID_BITS-1:0]            left_id;
    logic [ID_BITS-1:0]            right_id;
    logic signed [OFFSET_BITS-1:0] left_offset;
    logic signed [OFFSET_BITS-1:0] right_offset;
    logic [slga_pkg::SPAN_BITS-1:0] left_span;

    modport source(output valid, cmd, left_id, right_id, left_offset, right_offset,
                   left_span, input ready);
    modport sink(input valid, cmd, left_id, right_id, left_offset, right_offset,
                 left_span, output ready);
endinterface

interface slga_out_if;
    logic                               valid;
    logic                               ready;
    logic [slga_pkg::OUT_ID_BITS-1:0]   out_left_id;
    logic [slga_pkg::OUT_ID_BITS-1:0]   out_right_id;
    logic [slga_pkg::CNT_BITS-1:0]      link_count;
    logic signed [slga_pkg::SUM_BITS-1:0] left_sum;
    logic [slga_pkg::SUM_BITS-1:0]      left_square_sum;
    logic signed [slga_pkg::SUM_BITS-1:0] right_sum;
    logic [slga_pkg::SUM_BITS-1:0]      right_square_sum;
    logic                               end_marker;

    modport source(output valid, out_left_id, out_right_id, link_count, left_sum,
                   left_square_sum, right_sum, right_square_sum, end_marker, input ready);
    modport sink(input valid, out_left_id, out_right_id, link_count, left_sum,
                 left_square_sum, right_sum, right_square_sum, end_marker, output ready);
endinterface

interface slga_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [slga_pkg::CFG_BITS-1:0]  data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

// File: sv/slga_ctrl.sv
// Controller state machine of the sorted link group aggregator.
// Depends on slga_pkg; drives datapath commands from datapath status.
module slga_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  slga_pkg::t_sts i_sts,
    output slga_pkg::t_cmd o_cmd
);
    import slga_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SQUARE;
            end
            S_SQUARE: n_state = S_DECIDE;
            S_DECIDE: begin
                priority if (!i_sts.is_end && i_sts.match) n_state = S_IDLE;
                else if (i_sts.open) n_state = S_DIV;
                else n_state = S_AFTER;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_FIX;
            end
            S_FIX: n_state = S_DIST;
            S_DIST: n_state = S_CHECK;
            S_CHECK: n_state = i_sts.keep ? S_EMIT_GRP : S_AFTER;
            S_EMIT_GRP: begin
                if (i_sts.out_free) n_state = S_AFTER;
            end
            S_AFTER: n_state = i_sts.is_end ? S_MARK : S_IDLE;
            S_MARK: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            S_SQUARE: ;
            S_DECIDE: begin
                o_cmd.accumulate = !i_sts.is_end && i_sts.match;
                o_cmd.div_start  = !(!i_sts.is_end && i_sts.match) && i_sts.open;
            end
            S_DIV: o_cmd.div_step = !i_sts.div_done;
            S_FIX: o_cmd.fix_avg = 1'b1;
            S_DIST: o_cmd.calc_dist = 1'b1;
            S_CHECK: ;
            S_EMIT_GRP: o_cmd.emit_group = i_sts.out_free;
            S_AFTER: o_cmd.load_group = !i_sts.is_end;
            S_MARK: begin
                o_cmd.emit_mark   = i_sts.out_free;
                o_cmd.clear_group = i_sts.out_free;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit_group && o_cmd.emit_mark))
        else $error("group and marker emitted together");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch_in |=> r_state == S_SQUARE)
        else $error("accepted item not processed");
    a_div_leads_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_done) |=> o_cmd.fix_avg)
        else $error("division result skipped");
`endif

endmodule

// File: sv/slga_dp.sv
// Datapath of the sorted link group aggregator: item latch, group accumulators,
// bit-serial averaging dividers, distance check and result register. Uses slga_pkg.
module slga_dp #(
    parameter int ID_BITS     = 48,
    parameter int OFFSET_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    slga_in_if.sink        i_in,
    slga_out_if.source     o_out,
    slga_cfg_if.sink       i_cfg,
    input  slga_pkg::t_cmd i_cmd,
    output slga_pkg::t_sts o_sts
);
    import slga_pkg::*;

    logic                      r_cmd_end;
    logic [ID_BITS-1:0]        r_in_lid;
    logic [ID_BITS-1:0]        r_in_rid;
    logic signed [OFFSET_BITS-1:0] r_in_lo;
    logic signed [OFFSET_BITS-1:0] r_in_ro;
    logic [SPAN_BITS-1:0]      r_in_span;
    logic signed [2*OFFSET_BITS-1:0] r_sq_lo;
    logic signed [2*OFFSET_BITS-1:0] r_sq_ro;

    logic                      r_open;
    logic [ID_BITS-1:0]        r_gl;
    logic [ID_BITS-1:0]        r_gr;
    logic [SPAN_BITS-1:0]      r_span;
    logic [CNT_BITS-1:0]       r_count;
    logic [SUM_BITS-1:0]       r_sum_l;
    logic [SUM_BITS-1:0]       r_sqs_l;
    logic [SUM_BITS-1:0]       r_sum_r;
    logic [SUM_BITS-1:0]       r_sqs_r;
    logic [CFG_BITS-1:0]       r_max;

    logic [SUM_BITS-1:0]       r_dl;
    logic [SUM_BITS-1:0]       r_dr;
    logic [CNT_BITS-1:0]       r_rl;
    logic [CNT_BITS-1:0]       r_rr;
    logic                      r_nl;
    logic                      r_nr;
    logic [STEP_BITS-1:0]      r_steps;
    logic [SUM_BITS-1:0]       r_la;
    logic [SUM_BITS-1:0]       r_ra;
    logic [SUM_BITS-1:0]       r_dist;

    logic                      r_out_valid;
    logic [OUT_ID_BITS-1:0]    r_o_lid;
    logic [OUT_ID_BITS-1:0]    r_o_rid;
    logic [CNT_BITS-1:0]       r_o_cnt;
    logic [SUM_BITS-1:0]       r_o_suml;
    logic [SUM_BITS-1:0]       r_o_sqsl;
    logic [SUM_BITS-1:0]       r_o_sumr;
    logic [SUM_BITS-1:0]       r_o_sqsr;
    logic                      r_o_mark;

    logic [SUM_BITS-1:0]       w_lo_ext;
    logic [SUM_BITS-1:0]       w_ro_ext;
    logic [SUM_BITS-1:0]       w_sq_lo;
    logic [SUM_BITS-1:0]       w_sq_ro;
    logic [CNT_BITS:0]         w_rem_l;
    logic [CNT_BITS:0]         w_rem_r;
    logic                      w_ge_l;
    logic                      w_ge_r;
    logic [SUM_BITS-1:0]       w_gl64;
    logic [SUM_BITS-1:0]       w_gr64;

    assign w_lo_ext = SUM_BITS'(r_in_lo);
    assign w_ro_ext = SUM_BITS'(r_in_ro);
    assign w_sq_lo  = SUM_BITS'(r_sq_lo);
    assign w_sq_ro  = SUM_BITS'(r_sq_ro);
    assign w_gl64   = SUM_BITS'(r_gl);
    assign w_gr64   = SUM_BITS'(r_gr);

    assign w_rem_l = {r_rl, r_dl[SUM_BITS-1]};
    assign w_rem_r = {r_rr, r_dr[SUM_BITS-1]};
    assign w_ge_l  = w_rem_l >= {1'b0, r_count};
    assign w_ge_r  = w_rem_r >= {1'b0, r_count};

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (i_cfg.valid) begin
            r_max <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd_end <= i_in.cmd;
            r_in_lid  <= i_in.left_id;
            r_in_rid  <= i_in.right_id;
            r_in_lo   <= i_in.left_offset;
            r_in_ro   <= i_in.right_offset;
            r_in_span <= i_in.left_span;
        end
        r_sq_lo <= r_in_lo * r_in_lo;
        r_sq_ro <= r_in_ro * r_in_ro;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_group) begin
            r_open  <= 1'b0;
            r_gl    <= '0;
            r_gr    <= '0;
            r_span  <= '0;
            r_count <= '0;
            r_sum_l <= '0;
            r_sqs_l <= '0;
            r_sum_r <= '0;
            r_sqs_r <= '0;
        end else if (i_cmd.load_group) begin
            r_open  <= 1'b1;
            r_gl    <= r_in_lid;
            r_gr    <= r_in_rid;
            r_span  <= r_in_span;
            r_count <= CNT_BITS'(1);
            r_sum_l <= w_lo_ext;
            r_sqs_l <= w_sq_lo;
            r_sum_r <= w_ro_ext;
            r_sqs_r <= w_sq_ro;
        end else if (i_cmd.accumulate) begin
            if (r_count != '1) r_count <= r_count + CNT_BITS'(1);
            r_sum_l <= r_sum_l + w_lo_ext;
            r_sqs_l <= r_sqs_l + w_sq_lo;
            r_sum_r <= r_sum_r + w_ro_ext;
            r_sqs_r <= r_sqs_r + w_sq_ro;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else if (i_cmd.div_start) begin
            r_steps <= STEP_BITS'(DIV_STEPS);
        end else if (i_cmd.div_step) begin
            r_steps <= r_steps - STEP_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_nl <= r_sum_l[SUM_BITS-1];
            r_nr <= r_sum_r[SUM_BITS-1];
            r_dl <= r_sum_l[SUM_BITS-1] ? -r_sum_l : r_sum_l;
            r_dr <= r_sum_r[SUM_BITS-1] ? -r_sum_r : r_sum_r;
            r_rl <= '0;
            r_rr <= '0;
        end else if (i_cmd.div_step) begin
            r_dl <= {r_dl[SUM_BITS-2:0], w_ge_l};
            r_dr <= {r_dr[SUM_BITS-2:0], w_ge_r};
            r_rl <= w_ge_l ? CNT_BITS'(w_rem_l - {1'b0, r_count}) : CNT_BITS'(w_rem_l);
            r_rr <= w_ge_r ? CNT_BITS'(w_rem_r - {1'b0, r_count}) : CNT_BITS'(w_rem_r);
        end
        if (i_cmd.fix_avg) begin
            r_la <= r_nl ? -r_dl : r_dl;
            r_ra <= r_nr ? -r_dr : r_dr;
        end
        if (i_cmd.calc_dist) begin
            r_dist <= r_ra + SUM_BITS'(r_span) - r_la;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_group || i_cmd.emit_mark) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_group) begin
            r_o_lid  <= w_gl64[OUT_ID_BITS-1:0];
            r_o_rid  <= w_gr64[OUT_ID_BITS-1:0];
            r_o_cnt  <= r_count;
            r_o_suml <= r_sum_l;
            r_o_sqsl <= r_sqs_l;
            r_o_sumr <= r_sum_r;
            r_o_sqsr <= r_sqs_r;
            r_o_mark <= 1'b0;
        end else if (i_cmd.emit_mark) begin
            r_o_lid  <= '0;
            r_o_rid  <= '0;
            r_o_cnt  <= '0;
            r_o_suml <= '0;
            r_o_sqsl <= '0;
            r_o_sumr <= '0;
            r_o_sqsr <= '0;
            r_o_mark <= 1'b1;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.out_left_id      = r_o_lid;
    assign o_out.out_right_id     = r_o_rid;
    assign o_out.link_count       = r_o_cnt;
    assign o_out.left_sum         = $signed(r_o_suml);
    assign o_out.left_square_sum  = r_o_sqsl;
    assign o_out.right_sum        = $signed(r_o_sumr);
    assign o_out.right_square_sum = r_o_sqsr;
    assign o_out.end_marker       = r_o_mark;

    assign o_sts.is_end   = r_cmd_end;
    assign o_sts.match    = r_open && (r_in_lid == r_gl) && (r_in_rid == r_gr);
    assign o_sts.open     = r_open;
    assign o_sts.div_done = (r_steps == '0);
    assign o_sts.keep     = r_dist[SUM_BITS-1] || (r_dist <= SUM_BITS'(r_max));
    assign o_sts.out_free = !r_out_valid;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_group || i_cmd.emit_mark) |-> !r_out_valid)
        else $error("result register overwritten");
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_steps != '0)
        else $error("divider stepped past its end");
    a_acc_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accumulate || i_cmd.div_start) |-> r_open && r_count != '0)
        else $error("group used while closed");
`endif

endmodule

// File: sv/sorted_link_group_aggregator_top.sv
// Top level of the sorted link group aggregator.
// Depends on slga_pkg, the channel interfaces, slga_ctrl and slga_dp.
//
// Usage: link items enter on i_in, sorted by (left_id, right_id); cmd high
// marks end of stream. Results leave on o_out; i_cfg writes max_insert_size.
// Channels use valid/ready; an item moves when both are high.
// An item whose key matches the open group is accepted, squared and
// accumulated; an item that opens a group with none open is accepted,
// squared and loaded. An item that closes a group first waits on the two
// 64-step bit-serial averaging dividers, the distance check and, once the
// output register is free, the emit of its result.
// An end item emits the open group (if kept) and then an end marker.
// Reset (synchronous, active low) clears the open group, max_insert_size
// and the output valid. When the receiver stalls, the result stays in the
// output register; the block still accepts the next item and stalls only
// when it must emit a second result.
module sorted_link_group_aggregator_top #(
    parameter int ID_BITS     = 48,
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slga_in_if.sink     i_in,
    slga_out_if.source  o_out,
    slga_cfg_if.sink    i_cfg
);
    import slga_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    slga_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    slga_dp #(
        .ID_BITS     (ID_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule
